### design/rtss_pkg.sv
package rtss_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int STAGE_W    = 8;
	localparam int TALLY_W    = 2;
	localparam int PIN_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [STAGE_W-1:0]  stage_t;
	typedef logic [PIN_W-1:0]    pins_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 1'd1;

	localparam stage_t  SCAN_INTERVAL_RST   = 8'd50;
	localparam sample_t PRESS_THRESHOLD_RST = 10'd100;

	// scan stages
	localparam stage_t STAGE_X_DRIVE  = 8'd1;
	localparam stage_t STAGE_DETECT   = 8'd2;
	localparam stage_t STAGE_X_SAMPLE = 8'd3;
	localparam stage_t STAGE_Y_SAMPLE = 8'd4;

	// pin bits: Y+, X-, X+, Y-
	localparam pins_t PIN_YP  = 4'b0001;
	localparam pins_t PIN_XM  = 4'b0010;
	localparam pins_t PIN_XP  = 4'b0100;
	localparam pins_t PIN_YM  = 4'b1000;
	localparam pins_t PIN_ALL = 4'b1111;

	localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd2;

	typedef struct packed {
		sample_t ch0_sample;
		sample_t ch1_sample;
	} tick_t;

	typedef struct packed {
		logic    pressed_now;
		logic    key_held;
		logic    scan_busy;
		sample_t x_position;
		sample_t y_position;
		pins_t   drive_dir;
		pins_t   drive_level;
	} result_t;

	typedef struct packed {
		stage_t             stage;
		logic               pen_down;
		logic [TALLY_W-1:0] tally;
		logic               held;
		logic               busy;
		sample_t            x_latch;
		sample_t            y_latch;
		pins_t              dir;
		pins_t              level;
	} scan_state_t;

endpackage

### design/rtss_stream_if.sv
interface rtss_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/rtss_step.sv
// Next-state logic for one scan tick.
module rtss_step (
	input  rtss_pkg::scan_state_t cur,
	input  rtss_pkg::tick_t       tick_in,
	input  rtss_pkg::stage_t      scan_interval,
	input  rtss_pkg::sample_t     press_threshold,
	output rtss_pkg::scan_state_t nxt,
	output logic                  pressed
);
	import rtss_pkg::*;

	stage_t stage_inc;

	always_comb begin
		nxt     = cur;
		pressed = 1'b0;
		case (cur.stage)
			STAGE_X_DRIVE: begin
				nxt.busy     = 1'b1;
				nxt.pen_down = 1'b0;
				nxt.x_latch  = '0;
				nxt.y_latch  = '0;
				nxt.dir      = PIN_XM | PIN_XP;
				nxt.level    = PIN_YP | PIN_YM;
			end
			STAGE_DETECT: begin
				if (tick_in.ch0_sample < press_threshold) begin
					nxt.pen_down = 1'b1;
					pressed      = 1'b1;
					if (cur.tally < TALLY_MAX)
						nxt.tally = cur.tally + 2'd1;
					// held once the count reaches two
					if (cur.tally != '0)
						nxt.held = 1'b1;
					nxt.dir   = PIN_YP | PIN_YM;
					nxt.level = PIN_YP | PIN_XM | PIN_XP;
				end else begin
					nxt.busy  = 1'b0;
					nxt.dir   = PIN_ALL;
					nxt.level = PIN_ALL;
				end
			end
			STAGE_X_SAMPLE: begin
				if (cur.pen_down) begin
					nxt.x_latch = tick_in.ch1_sample;
					nxt.dir     = PIN_XM | PIN_XP;
					nxt.level   = PIN_YP | PIN_XP | PIN_YM;
				end
			end
			STAGE_Y_SAMPLE: begin
				if (cur.pen_down) begin
					nxt.y_latch = tick_in.ch0_sample;
				end else begin
					nxt.held  = 1'b0;
					nxt.tally = '0;
				end
				nxt.busy  = 1'b0;
				nxt.dir   = PIN_ALL;
				nxt.level = PIN_ALL;
			end
			default: begin
			end
		endcase

		// 8-bit counter wraps naturally at 255
		stage_inc = cur.stage + 8'd1;
		nxt.stage = (stage_inc > scan_interval) ? '0 : stage_inc;
	end

endmodule

### design/resistive_touch_scan_sequencer.sv
// A result is registered and appears on res in the cycle after its tick transfer.
// Throughput: one tick per cycle while res accepts results; the output register frees as it transfers.
// Reset (arst_n low, async): stage 0, flags and coordinates cleared, pins
// released (dir/level all ones), scan_interval 50, press_threshold 100,
// no result pending.
module resistive_touch_scan_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	rtss_stream_if.sink                         tick,
	rtss_stream_if.source                       res,
	input  logic                                cfg_we,
	input  logic [rtss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import rtss_pkg::*;

	// config registers
	stage_t  scan_interval_q;
	sample_t press_threshold_q;

	// scan state and result register
	scan_state_t state_q;
	scan_state_t state_nxt;
	logic        pressed;
	result_t     res_q;
	logic        res_valid_q;

	logic tick_xfer;

	// New tick is taken whenever the result slot is empty or draining now.
	assign tick.ready = !res_valid_q || res.ready;
	assign tick_xfer  = tick.valid && tick.ready;

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	rtss_step u_step (
		.cur             (state_q),
		.tick_in         (tick.data),
		.scan_interval   (scan_interval_q),
		.press_threshold (press_threshold_q),
		.nxt             (state_nxt),
		.pressed         (pressed)
	);

	// configuration writes: make them only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_interval_q   <= SCAN_INTERVAL_RST;
			press_threshold_q <= PRESS_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_INTERVAL:   scan_interval_q   <= cfg_wdata[STAGE_W-1:0];
				REG_PRESS_THRESHOLD: press_threshold_q <= cfg_wdata[SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// scan state advances once per tick transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				stage:    '0,
				pen_down: 1'b0,
				tally:    '0,
				held:     1'b0,
				busy:     1'b0,
				x_latch:  '0,
				y_latch:  '0,
				dir:      PIN_ALL,
				level:    PIN_ALL
			};
		end else if (tick_xfer) begin
			state_q <= state_nxt;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_xfer) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload shows the state after the tick
	always_ff @(posedge clk) begin
		if (tick_xfer) begin
			res_q.pressed_now <= pressed;
			res_q.key_held    <= state_nxt.held;
			res_q.scan_busy   <= state_nxt.busy;
			res_q.x_position  <= state_nxt.x_latch;
			res_q.y_position  <= state_nxt.y_latch;
			res_q.drive_dir   <= state_nxt.dir;
			res_q.drive_level <= state_nxt.level;
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the resistive touch scan sequencer.
// Ticks are pushed onto a backlog that the source always block drains; the
// monitor predicts each accepted tick's readout and checks the readouts that
// come back, oldest first.
module tb;
	import rtss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 60;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rtss_stream_if #(.payload_t(tick_t))   tick_ch ();
	rtss_stream_if #(.payload_t(result_t)) res_ch ();

	resistive_touch_scan_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ticks waiting to be offered, and readouts predicted but not yet seen
	tick_t   tick_backlog[$];
	result_t pending_readouts[$];

	int ticks_queued = 0;
	int ticks_taken  = 0;
	int mismatches   = 0;
	int cycle_count  = 0;

	// idling control: idle_on enables random gaps on both sides
	bit idle_on;
	bit hold_long_req;
	bit hold_long_done = 1'b0;
	int src_hold;
	int sink_hold;

	// predictor's copy of the scan state and the two registers
	scan_state_t scan_st;
	stage_t      cur_interval;
	sample_t     cur_threshold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Walk the scan one stage for a single tick and return the readout
	// that shows the state after it.
	function automatic result_t step_scan(input tick_t t);
		result_t r;
		logic    hit;
		stage_t  nxt;
		hit = 1'b0;
		case (scan_st.stage)
			STAGE_X_DRIVE: begin
				// claim the pins, forget the last position, drive the X plate
				scan_st.busy     = 1'b1;
				scan_st.pen_down = 1'b0;
				scan_st.x_latch  = '0;
				scan_st.y_latch  = '0;
				scan_st.dir      = PIN_XM | PIN_XP;
				scan_st.level    = PIN_YP | PIN_YM;
			end
			STAGE_DETECT: begin
				if (t.ch0_sample < cur_threshold) begin
					scan_st.pen_down = 1'b1;
					hit = 1'b1;
					// tally saturates; second press onward means held
					if (scan_st.tally < TALLY_MAX)
						scan_st.tally = scan_st.tally + 1'b1;
					if (scan_st.tally > 1)
						scan_st.held = 1'b1;
					scan_st.dir   = PIN_YP | PIN_YM;
					scan_st.level = PIN_YP | PIN_XM | PIN_XP;
				end else begin
					scan_st.busy  = 1'b0;
					scan_st.dir   = PIN_ALL;
					scan_st.level = PIN_ALL;
				end
			end
			STAGE_X_SAMPLE: begin
				// with no pen this stage leaves everything alone
				if (scan_st.pen_down) begin
					scan_st.x_latch = t.ch1_sample;
					scan_st.dir     = PIN_XM | PIN_XP;
					scan_st.level   = PIN_YP | PIN_XP | PIN_YM;
				end
			end
			STAGE_Y_SAMPLE: begin
				if (scan_st.pen_down) begin
					scan_st.y_latch = t.ch0_sample;
				end else begin
					// no press this round: touch history is dropped
					scan_st.held  = 1'b0;
					scan_st.tally = '0;
				end
				scan_st.busy  = 1'b0;
				scan_st.dir   = PIN_ALL;
				scan_st.level = PIN_ALL;
			end
			default: ;
		endcase
		// 8-bit counter: from 255 the increment wraps to 0 on its own
		nxt = scan_st.stage + 1'b1;
		scan_st.stage = (nxt > cur_interval) ? '0 : nxt;

		r.pressed_now = hit;
		r.key_held    = scan_st.held;
		r.scan_busy   = scan_st.busy;
		r.x_position  = scan_st.x_latch;
		r.y_position  = scan_st.y_latch;
		r.drive_dir   = scan_st.dir;
		r.drive_level = scan_st.level;
		return r;
	endfunction

	function automatic void check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
		end
	endfunction

	function automatic void check_readout(input result_t want, input result_t got);
		check_field("pressed_now", 32'(want.pressed_now), 32'(got.pressed_now));
		check_field("key_held",    32'(want.key_held),    32'(got.key_held));
		check_field("scan_busy",   32'(want.scan_busy),   32'(got.scan_busy));
		check_field("x_position",  32'(want.x_position),  32'(got.x_position));
		check_field("y_position",  32'(want.y_position),  32'(got.y_position));
		check_field("drive_dir",   32'(want.drive_dir),   32'(got.drive_dir));
		check_field("drive_level", 32'(want.drive_level), 32'(got.drive_level));
	endfunction

	// Tick source. A new tick goes out only once the held one has transferred.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			src_hold <= 0;
		end else if (!tick_ch.valid || tick_ch.ready) begin
			if (src_hold != 0) begin
				src_hold <= src_hold - 1;
				tick_ch.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				src_hold <= $urandom_range(0, 16);
				tick_ch.valid <= 1'b0;
			end else if (tick_backlog.size() != 0) begin
				tick_ch.data  <= tick_backlog.pop_front();
				tick_ch.valid <= 1'b1;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// Readout sink: random stalls, plus one long hold-off on request so the
	// output register fills and the block pushes back on the tick side.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_hold <= 0;
		end else if (hold_long_req && !hold_long_done) begin
			hold_long_done <= 1'b1;
			sink_hold <= LONG_HOLD;
			res_ch.ready <= 1'b0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			sink_hold <= $urandom_range(0, 16);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Monitor: check the readout transfer first, then predict from the tick
	// transfer of the same edge (its readout comes in the next cycle at the
	// earliest).
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_readouts.size() == 0) begin
					mismatches++;
					$display("%0t: readout with nothing expected, got %h", $time,
						res_ch.data);
				end else begin
					check_readout(pending_readouts.pop_front(), res_ch.data);
				end
			end
			if (tick_ch.valid && tick_ch.ready) begin
				pending_readouts.push_back(step_scan(tick_ch.data));
				ticks_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic queue_tick(input int unsigned ch0, input int unsigned ch1);
		tick_t t;
		t.ch0_sample = ch0[SAMPLE_W-1:0];
		t.ch1_sample = ch1[SAMPLE_W-1:0];
		tick_backlog.push_back(t);
		ticks_queued++;
	endtask

	// channel 0 leans toward presses so that scans get past the detect stage
	function automatic int unsigned pick_ch0(input sample_t thr);
		case ($urandom_range(0, 7))
			0, 1, 2: return (thr != 0) ? $urandom_range(0, thr - 1) : 0;
			3:       return (thr != 0) ? thr - 1 : 0;
			4:       return 32'(thr);
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	function automatic int unsigned pick_threshold();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 1023;
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	// Wait until every queued tick has transferred and every readout has come,
	// then give the registered output a little slack.
	task automatic settle();
		while (ticks_taken != ticks_queued || pending_readouts.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SCAN_INTERVAL)
			cur_interval = val[STAGE_W-1:0];
		else if (idx == REG_PRESS_THRESHOLD)
			cur_threshold = val;
	endtask

	// One block of random ticks under a fixed setting; upper data bits of an
	// interval write are junk that the register must drop.
	task automatic run_phase(input int unsigned interval, input int unsigned thr,
			input int n);
		logic [CFG_DATA_W-1:0] wd;
		wd = CFG_DATA_W'($urandom_range(0, 1023));
		wd[STAGE_W-1:0] = interval[STAGE_W-1:0];
		write_reg(REG_SCAN_INTERVAL, wd);
		write_reg(REG_PRESS_THRESHOLD, thr[CFG_DATA_W-1:0]);
		for (int k = 0; k < n; k++)
			queue_tick(pick_ch0(cur_threshold), $urandom_range(0, 1023));
		settle();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on        = 1'b0;
		hold_long_req  = 1'b0;

		scan_st       = '0;
		scan_st.dir   = PIN_ALL;
		scan_st.level = PIN_ALL;
		cur_interval  = SCAN_INTERVAL_RST;
		cur_threshold = PRESS_THRESHOLD_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, reset settings: stages 0..4 of the first scan ---
		queue_tick(0, 1023);
		queue_tick(1023, 0);
		queue_tick(99, 'h2AA);       // just under the default threshold
		queue_tick(100, 1023);       // X latches full scale
		queue_tick(1023, 0);         // Y latches full scale
		settle();

		// shortest interval that runs every stage, highest threshold: every scan sees a
		// press, so the tally climbs to its ceiling and key_held sets
		write_reg(REG_SCAN_INTERVAL, 10'd4);
		write_reg(REG_PRESS_THRESHOLD, 10'd1023);
		for (int k = 0; k < 16; k++)
			queue_tick(k[0] ? 1022 : 0, k[0] ? 'h155 : 'h3FF);
		settle();

		// zero threshold: nothing presses, stage 4 drops the touch history
		write_reg(REG_PRESS_THRESHOLD, 10'd0);
		for (int k = 0; k < 5; k++)
			queue_tick(0, 1023);
		settle();

		// --- random part ---
		idle_on = 1'b1;

		// long receiver hold-off while ticks keep coming
		@(posedge clk);
		hold_long_req <= 1'b1;
		run_phase(4, pick_threshold(), 150);

		// short intervals: stages above the interval never run
		run_phase(0, $urandom_range(0, 1023), 20);
		run_phase(1, 1023, 20);
		run_phase(2, 1023, 20);
		run_phase(3, 1023, 25);

		// longest interval, long enough to see the counter wrap past 255
		run_phase(255, $urandom_range(1, 1023), 280);

		for (int p = 0; p < 8; p++)
			run_phase($urandom_range(4, 9), pick_threshold(), 60);

		// back to the reset values
		run_phase(32'(SCAN_INTERVAL_RST), 32'(PRESS_THRESHOLD_RST), 60);

		// closing stretch at full rate
		idle_on = 1'b0;
		run_phase(5, $urandom_range(1, 1023), 100);

		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

### sim.f
design/rtss_pkg.sv
design/rtss_stream_if.sv
design/rtss_step.sv
design/resistive_touch_scan_sequencer.sv
tb/tb.sv
